// File: design/tassg_pkg.sv
// Shared types and constants for the three-axis synchronized step generator.
// No dependencies.
package tassg_pkg;

    localparam int NUM_AXES = 3;
    localparam int AXIS_SEL_W = 2;
    localparam int FIELD_STEPS_W = 24;
    localparam int PERIOD_W = 16;
    localparam int DONE_W = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ENQUEUE = 1'b1;

    typedef struct packed {
        logic pulse;
        logic dir;
        logic run;
        logic wait_bar;
        logic adv_wait;
        logic full;
    } t_axis_stat;

endpackage

// File: design/tassg_in_if.sv
// Input channel of the step generator: valid/ready plus one command item.
// Depends on tassg_pkg.
interface tassg_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [tassg_pkg::AXIS_SEL_W-1:0]    axis_select;
    logic [tassg_pkg::FIELD_STEPS_W-1:0] move_steps;
    logic                                move_direction;
    logic [tassg_pkg::PERIOD_W-1:0]      move_period;

    modport source (output valid, cmd, axis_select, move_steps, move_direction, move_period,
                    input ready);
    modport sink (input valid, cmd, axis_select, move_steps, move_direction, move_period,
                  output ready);
endinterface

// File: design/tassg_out_if.sv
// Output channel of the step generator: valid/ready plus one status item.
// Depends on tassg_pkg.
interface tassg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [tassg_pkg::NUM_AXES-1:0]       step_pulses;
    logic [tassg_pkg::NUM_AXES-1:0]       direction_levels;
    logic [tassg_pkg::NUM_AXES-1:0]       running_mask;
    logic [tassg_pkg::NUM_AXES-1:0]       waiting_mask;
    logic                                 enqueue_rejected;
    logic [tassg_pkg::DONE_W-1:0]         moves_done_x;
    logic [tassg_pkg::DONE_W-1:0]         moves_done_y;
    logic [tassg_pkg::DONE_W-1:0]         moves_done_z;

    modport source (output valid, step_pulses, direction_levels, running_mask, waiting_mask,
                    enqueue_rejected, moves_done_x, moves_done_y, moves_done_z,
                    input ready);
    modport sink (input valid, step_pulses, direction_levels, running_mask, waiting_mask,
                  enqueue_rejected, moves_done_x, moves_done_y, moves_done_z,
                  output ready);
endinterface

// File: design/tassg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tassg_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/tassg_queue.sv
// Per-axis move FIFO: pointers and fill count around one tassg_ram.
// The read port always prefetches the next head; a same-cycle write is bypassed.
module tassg_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int WIDTH = 41
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);
    localparam int IW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);

    logic [IW-1:0]    r_head, r_tail, n_head, n_tail;
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_byp;
    logic [WIDTH-1:0] r_byp_data;
    logic [WIDTH-1:0] w_rdata;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + IW'(1);
            n_fill = r_fill - FW'(1);
        end else if (i_push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + IW'(1);
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_byp  <= i_push && (r_tail == n_head);
        end
        r_byp_data <= i_wdata;
    end

    tassg_ram #(
        .WIDTH(WIDTH),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_push),
        .i_waddr(r_tail),
        .i_wdata(i_wdata),
        .i_raddr(n_head),
        .o_rdata(w_rdata)
    );

    assign o_head  = r_byp ? r_byp_data : w_rdata;
    assign o_full  = (r_fill == FULL_CNT);
    assign o_empty = (r_fill == '0);
endmodule

// File: design/tassg_axis.sv
// One stepper axis: phase sequencer, active move, step/period counters, done count.
// Depends on tassg_pkg and tassg_queue.
module tassg_axis #(
    parameter int QUEUE_DEPTH = 8,
    parameter int STEP_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_tick,
    input  logic                                  i_release,
    input  logic                                  i_push,
    input  logic [tassg_pkg::FIELD_STEPS_W-1:0]   i_move_steps,
    input  logic                                  i_move_direction,
    input  logic [tassg_pkg::PERIOD_W-1:0]        i_move_period,
    output tassg_pkg::t_axis_stat                 o_stat,
    output logic [tassg_pkg::DONE_W-1:0]          o_done
);
    import tassg_pkg::*;

    localparam int SW = STEP_BITS < FIELD_STEPS_W ? STEP_BITS : FIELD_STEPS_W;
    localparam int MW = SW + 1 + PERIOD_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_WAIT
    } t_phase;

    t_phase              r_phase, a_phase, n_phase;
    logic [SW-1:0]       r_steps, n_steps;
    logic                r_dir, n_dir;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [SW-1:0]       r_sc, a_sc, n_sc, sc_inc;
    logic [PERIOD_W-1:0] r_pc, a_pc, n_pc, pc_inc;
    logic [DONE_W-1:0]   r_done, n_done;
    logic                pulse;
    logic                pop;
    logic [MW-1:0]       wdata, head;
    logic                full, empty;

    assign wdata  = {i_move_steps[SW-1:0], i_move_direction, i_move_period};
    assign sc_inc = r_sc + SW'(1);
    assign pc_inc = r_pc + PERIOD_W'(1);

    // advance running axis
    always_comb begin
        a_phase = r_phase;
        a_sc    = r_sc;
        a_pc    = r_pc;
        pulse   = 1'b0;
        if (i_tick && r_phase == PH_RUN) begin
            if (pc_inc < r_period) begin
                a_pc = pc_inc;
            end else begin
                a_pc = '0;
                if (r_steps == '0) begin
                    a_phase = PH_WAIT;
                end else begin
                    pulse = 1'b1;
                    a_sc  = sc_inc;
                    if (sc_inc == r_steps) begin
                        a_phase = PH_WAIT;
                    end
                end
            end
        end
    end

    // barrier release, then load
    always_comb begin
        n_phase  = a_phase;
        n_sc     = a_sc;
        n_pc     = a_pc;
        n_done   = r_done;
        n_steps  = r_steps;
        n_dir    = r_dir;
        n_period = r_period;
        pop      = 1'b0;
        if (i_tick && i_release) begin
            n_done  = r_done + DONE_W'(1);
            n_phase = PH_IDLE;
        end
        if (i_tick && n_phase == PH_IDLE && !empty) begin
            pop      = 1'b1;
            n_steps  = head[MW-1:PERIOD_W+1];
            n_dir    = head[PERIOD_W];
            n_period = head[PERIOD_W-1:0];
            n_sc     = '0;
            n_pc     = '0;
            n_phase  = PH_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_steps  <= '0;
            r_dir    <= 1'b0;
            r_period <= '0;
            r_sc     <= '0;
            r_pc     <= '0;
            r_done   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_steps  <= n_steps;
            r_dir    <= n_dir;
            r_period <= n_period;
            r_sc     <= n_sc;
            r_pc     <= n_pc;
            r_done   <= n_done;
        end
    end

    tassg_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .WIDTH(MW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_wdata(wdata),
        .i_pop  (pop),
        .o_head (head),
        .o_full (full),
        .o_empty(empty)
    );

    always_comb begin
        o_stat.pulse    = pulse;
        o_stat.dir      = n_dir;
        o_stat.run      = (n_phase == PH_RUN);
        o_stat.wait_bar = (n_phase == PH_WAIT);
        o_stat.adv_wait = (a_phase == PH_WAIT);
        o_stat.full     = full;
    end

    assign o_done = n_done;
endmodule

// File: design/three_axis_synced_step_generator_unit.sv
// Three-axis synchronized step generator, top level.
// Each move queue prefetches its head through the RAM read port; output status is registered.
// Throughput: one item per cycle unless the output is stalled by o_out.ready.
// Reset (synchronous, active low) empties all queues and clears phases, moves and counters;
// queue RAM contents are not cleared.
// Depends on tassg_pkg, tassg_in_if, tassg_out_if and tassg_axis.
module three_axis_synced_step_generator_unit #(
    parameter int QUEUE_DEPTH = 8,
    parameter int STEP_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tassg_in_if.sink     i_in,
    tassg_out_if.source  o_out
);
    import tassg_pkg::*;

    logic                  accept, tick, enq, release_all, rejected;
    logic [NUM_AXES-1:0]   push, adv_wait, full;
    t_axis_stat            w_stat [NUM_AXES];
    logic [DONE_W-1:0]     w_done [NUM_AXES];
    logic [NUM_AXES-1:0]   n_pulses, n_dirs, n_run, n_wait;

    logic                  r_valid;
    logic [NUM_AXES-1:0]   r_pulses, r_dirs, r_run, r_wait;
    logic                  r_rejected;
    logic [DONE_W-1:0]     r_done_x, r_done_y, r_done_z;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign tick        = accept && (i_in.cmd == CMD_TICK);
    assign enq         = accept && (i_in.cmd == CMD_ENQUEUE);
    assign release_all = &adv_wait;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        assign push[a]     = enq && (i_in.axis_select == AXIS_SEL_W'(a)) && !full[a];
        assign adv_wait[a] = w_stat[a].adv_wait;
        assign full[a]     = w_stat[a].full;

        tassg_axis #(
            .QUEUE_DEPTH(QUEUE_DEPTH),
            .STEP_BITS(STEP_BITS)
        ) u_axis (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_tick          (tick),
            .i_release       (release_all),
            .i_push          (push[a]),
            .i_move_steps    (i_in.move_steps),
            .i_move_direction(i_in.move_direction),
            .i_move_period   (i_in.move_period),
            .o_stat          (w_stat[a]),
            .o_done          (w_done[a])
        );
    end

    always_comb begin
        rejected = 1'b0;
        if (i_in.cmd == CMD_ENQUEUE) begin
            rejected = 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
                if (i_in.axis_select == AXIS_SEL_W'(a) && !full[a]) begin
                    rejected = 1'b0;
                end
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            n_pulses[a] = w_stat[a].pulse;
            n_dirs[a]   = w_stat[a].dir;
            n_run[a]    = w_stat[a].run;
            n_wait[a]   = w_stat[a].wait_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (accept) begin
            r_pulses   <= n_pulses;
            r_dirs     <= n_dirs;
            r_run      <= n_run;
            r_wait     <= n_wait;
            r_rejected <= rejected;
            r_done_x   <= w_done[0];
            r_done_y   <= w_done[1];
            r_done_z   <= w_done[2];
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.step_pulses      = r_pulses;
    assign o_out.direction_levels = r_dirs;
    assign o_out.running_mask     = r_run;
    assign o_out.waiting_mask     = r_wait;
    assign o_out.enqueue_rejected = r_rejected;
    assign o_out.moves_done_x     = r_done_x;
    assign o_out.moves_done_y     = r_done_y;
    assign o_out.moves_done_z     = r_done_z;
endmodule
